>>> rtl/array_linked_list_manager_assert.svh
// Assertion macros for the array linked list manager
`ifndef ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH
`define ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define ALM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ALM_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ALM_ASSERT_IMP(label, clk, rst, a, c)
`define ALM_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package alm_pkg;
  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_LINEAR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,      // write reset contents at clear index
    OP_LD,       // capture command
    OP_RD_POS,   // read links and item of position
    OP_CHK,      // decide status from used bit and flags
    OP_INS_A,    // write new slot, capture next free link
    OP_INS_B,    // fix pos.next and n.prev, counters
    OP_DEL_A,    // fix p.next and n.prev
    OP_DEL_B,    // clear pos, link it to free chain, counters
    OP_WALK_RD,  // read next of cursor
    OP_WALK_ST,  // step cursor
    OP_LIN_RD,   // read item at cursor
    OP_LIN_WR,   // write scratch entry, advance
    OP_CP_RD,    // read scratch entry
    OP_CP_WR,    // write list entry in order, or free entry
    OP_DONE      // present result
  } op_t;

  typedef struct packed {
    op_t op;
  } alm_cmd_t;

  typedef struct packed {
    logic bad;      // status check failed
    logic last;     // sweep/walk finished
  } alm_stat_t;
endpackage

>>> rtl/alm_ram.sv
// ----------------------------------------------------------------------------
// alm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/alm_datapath.sv
// ----------------------------------------------------------------------------
// alm_datapath
// Table memories, free chain registers, cursor and result registers.
// ----------------------------------------------------------------------------
module alm_datapath #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  alm_pkg::alm_cmd_t ctl,
  output alm_pkg::alm_stat_t sts,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_pos,
  input  logic [31:0]       in_value,
  output logic [1:0]        r_status,
  output logic [31:0]       r_item,
  output logic [7:0]        r_slot,
  output logic [8:0]        r_count
);
  import alm_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // memories: item, next, prev, scratch
  logic          i_we, n_we, p_we, s_we;
  logic [AW-1:0] i_wa, n_wa, p_wa, s_wa, i_ra, n_ra, p_ra, s_ra;
  logic [DATA_WIDTH-1:0] i_wd, i_rd, s_wd, s_rd;
  logic [AW-1:0] n_wd, n_rd, p_wd, p_rd;

  alm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_item (
    .clk(clk), .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(i_ra), .rdata(i_rd));
  alm_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
  alm_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  alm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_scr (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  // used bits in flip-flops, read at one chosen slot
  logic [CAPACITY-1:0] used;
  logic [1:0]          cmd;
  logic [7:0]          pos;
  logic [DATA_WIDTH-1:0] val;
  logic [AW-1:0] fhead, cur, pslot, nslot, fnext;
  logic          fempty;
  logic [CW-1:0] ucount, idx;
  logic [1:0]    chk_status;
  logic          chk_bad;

  logic pos_in;
  assign pos_in = {1'b0, pos} < (9 + CW)'(CAPACITY);
  logic [AW-1:0] posa;
  assign posa = AW'(pos);

  // walk termination, also clear and copy sweeps
  logic [CW-1:0] idx1;
  assign idx1 = idx + CW'(1);

  // status of the captured command, known during the check step
  always_comb begin
    chk_status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (!pos_in || !used[posa]) chk_status = ST_BAD;
      else if (fempty) chk_status = ST_FULL;
    end else if (cmd == CMD_DELETE) begin
      if (pos == '0 || !pos_in || !used[posa]) chk_status = ST_BAD;
    end else if (cmd == CMD_FIND) begin
      if ({1'b0, pos} > (CW + 1)'(ucount)) chk_status = ST_BAD;
    end
    chk_bad = chk_status != ST_OK;
  end

  always_comb begin
    i_we = 1'b0; n_we = 1'b0; p_we = 1'b0; s_we = 1'b0;
    i_wa = posa; n_wa = posa; p_wa = posa; s_wa = idx[AW-1:0];
    i_wd = '0; n_wd = '0; p_wd = '0; s_wd = i_rd;
    i_ra = cur; n_ra = posa; p_ra = posa; s_ra = idx[AW-1:0];
    sts.bad = chk_bad;
    sts.last = 1'b0;
    unique case (ctl.op)
      OP_CLR: begin
        i_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
        i_wa = idx[AW-1:0]; n_wa = idx[AW-1:0]; p_wa = idx[AW-1:0];
        n_wd = (idx == '0 || idx1 == CAP) ? '0 : idx1[AW-1:0];
        sts.last = idx1 == CAP;
      end
      OP_RD_POS: begin
        n_ra = posa; i_ra = posa;
      end
      OP_CHK: n_ra = fhead;
      OP_INS_A: begin
        i_we = 1'b1; i_wa = fhead; i_wd = val;
        n_we = 1'b1; n_wa = fhead; n_wd = nslot;
        p_we = 1'b1; p_wa = fhead; p_wd = posa;
      end
      OP_INS_B: begin
        n_we = 1'b1; n_wa = posa; n_wd = fhead;
        p_we = 1'b1; p_wa = nslot; p_wd = fhead;
      end
      OP_DEL_A: begin
        n_we = 1'b1; n_wa = pslot; n_wd = nslot;
        p_we = 1'b1; p_wa = nslot; p_wd = pslot;
      end
      OP_DEL_B: begin
        i_we = 1'b1; i_wa = posa; i_wd = '0;
        n_we = 1'b1; n_wa = posa; n_wd = fempty ? '0 : fhead;
        p_we = 1'b1; p_wa = posa; p_wd = '0;
      end
      OP_WALK_RD: begin
        n_ra = cur;
        sts.last = idx == CW'(pos);
      end
      OP_WALK_ST: ;
      OP_LIN_RD: begin
        i_ra = cur; n_ra = cur;
        sts.last = idx == ucount;
      end
      OP_LIN_WR: s_we = 1'b1;
      OP_CP_RD: s_ra = idx[AW-1:0];
      OP_CP_WR: begin
        i_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
        i_wa = idx[AW-1:0]; n_wa = idx[AW-1:0]; p_wa = idx[AW-1:0];
        if (idx < ucount) begin
          i_wd = s_rd;
          n_wd = (idx1 == ucount) ? '0 : idx1[AW-1:0];
          p_wd = (idx == '0) ? AW'(ucount - CW'(1)) : AW'(idx - CW'(1));
        end else begin
          n_wd = (idx1 == CAP) ? '0 : idx1[AW-1:0];
        end
        sts.last = idx1 == CAP;
      end
      default: ;
    endcase
  end

  // registers of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= CAPACITY'(1);
      fhead  <= AW'(1);
      fempty <= 1'b0;
      ucount <= CW'(1);
      idx    <= '0;
    end else begin
      unique case (ctl.op)
        OP_CLR: idx <= idx1;
        OP_LD: begin
          cmd <= in_cmd; pos <= in_pos;
          val <= in_value[DATA_WIDTH-1:0];
          idx <= '0; cur <= '0;
          r_status <= ST_OK; r_item <= '0; r_slot <= '0;
        end
        OP_RD_POS: ;
        OP_CHK: begin
          pslot <= p_rd; nslot <= n_rd;
          r_status <= chk_status;
          if (cmd == CMD_DELETE && !chk_bad) r_item <= 32'(i_rd);
        end
        OP_INS_A: fnext <= n_rd;
        OP_INS_B: begin
          used[fhead] <= 1'b1;
          ucount <= ucount + CW'(1);
          r_slot <= 8'(fhead);
          if (ucount + CW'(1) >= CAP) begin fempty <= 1'b1; fhead <= '0; end
          else fhead <= fnext;
        end
        OP_DEL_A: ;
        OP_DEL_B: begin
          used[posa] <= 1'b0;
          fhead <= posa; fempty <= 1'b0;
          ucount <= ucount - CW'(1);
        end
        OP_WALK_RD: if (idx == CW'(pos)) r_slot <= 8'(cur);
        OP_WALK_ST: begin cur <= n_rd; idx <= idx1; end
        OP_LIN_RD: if (idx == ucount) idx <= '0;
        OP_LIN_WR: begin
          cur <= n_rd; idx <= idx1;
        end
        OP_CP_RD: ;
        OP_CP_WR: begin
          used[idx[AW-1:0]] <= idx < ucount;
          idx <= idx1;
          if (idx1 == CAP) begin
            fempty <= ucount >= CAP;
            fhead  <= (ucount >= CAP) ? '0 : ucount[AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign r_count = 9'(ucount);
endmodule

>>> rtl/alm_ctrl.sv
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer: clearing pass, command steps, walks and result handshake.
// ----------------------------------------------------------------------------
module alm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [1:0]         s_cmd,
  output logic               m_tvalid,
  input  logic               m_tready,
  output alm_pkg::alm_cmd_t  ctl,
  input  alm_pkg::alm_stat_t sts
);
  import alm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_CHK, S_INSA, S_INSB, S_DELA, S_DELB,
    S_WRD, S_WST, S_LRD, S_LWR, S_CRD, S_CWR, S_OUT
  } state_t;

  state_t state;
  logic [1:0] cmd;

  assign s_tready = state == S_IDLE;
  assign m_tvalid = state == S_OUT;

  always_comb begin
    unique case (state)
      S_CLR:  ctl.op = OP_CLR;
      S_IDLE: ctl.op = (s_tvalid) ? OP_LD : OP_NONE;
      S_RD:   ctl.op = OP_RD_POS;
      S_CHK:  ctl.op = OP_CHK;
      S_INSA: ctl.op = OP_INS_A;
      S_INSB: ctl.op = OP_INS_B;
      S_DELA: ctl.op = OP_DEL_A;
      S_DELB: ctl.op = OP_DEL_B;
      S_WRD:  ctl.op = OP_WALK_RD;
      S_WST:  ctl.op = OP_WALK_ST;
      S_LRD:  ctl.op = OP_LIN_RD;
      S_LWR:  ctl.op = OP_LIN_WR;
      S_CRD:  ctl.op = OP_CP_RD;
      S_CWR:  ctl.op = OP_CP_WR;
      S_OUT:  ctl.op = OP_DONE;
      default: ctl.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cmd   <= CMD_INSERT;
    end else begin
      unique case (state)
        S_CLR: if (sts.last) state <= S_IDLE;
        S_IDLE: if (s_tvalid) begin
          cmd <= s_cmd;
          state <= (s_cmd == CMD_LINEAR) ? S_LRD : S_RD;
        end
        S_RD: state <= S_CHK;
        // branch once status is known
        S_CHK: begin
          if (cmd == CMD_INSERT)      state <= sts.bad ? S_OUT : S_INSA;
          else if (cmd == CMD_DELETE) state <= sts.bad ? S_OUT : S_DELA;
          else                        state <= sts.bad ? S_OUT : S_WRD;
        end
        S_INSA: state <= S_INSB;
        S_INSB: state <= S_OUT;
        S_DELA: state <= S_DELB;
        S_DELB: state <= S_OUT;
        S_WRD: state <= sts.last ? S_OUT : S_WST;
        S_WST: state <= S_WRD;
        S_LRD: state <= sts.last ? S_CRD : S_LWR;
        S_LWR: state <= S_LRD;
        S_CRD: state <= S_CWR;
        S_CWR: state <= sts.last ? S_OUT : S_CRD;
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/array_linked_list_manager.sv
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Doubly linked list in a fixed table with a free chain; stream interface.
// ----------------------------------------------------------------------------
// Usage: one command transaction on s_axis gives one result transaction on
// m_axis. Commands: insert after, delete, find, linearize.
// Steps: each step waits on the registered-read table memories, one
// dependent link read per step; find walks the list up to the index and
// linearize walks the list and then sweeps the whole table.
// One command is in flight at a time; s_tready is low until the result
// has been taken, so a stalled m_tready holds the block.
// Reset: a clearing pass over all CAPACITY slots rebuilds the tables; no
// command is accepted meanwhile.
// ----------------------------------------------------------------------------
module array_linked_list_manager #(
  parameter int unsigned CAPACITY   = alm_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = alm_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd[1:0], position[9:2], value[41:10], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // status[1:0], item_value[33:2], slot[41:34],
                                 // count[50:42], zero
);
  import alm_pkg::*;

  alm_cmd_t  ctl;
  alm_stat_t sts;
  logic [1:0]  r_status;
  logic [31:0] r_item;
  logic [7:0]  r_slot;
  logic [8:0]  r_count;

  alm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_cmd(s_tdata[1:0]), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .ctl(ctl), .sts(sts));

  alm_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .in_cmd(s_tdata[1:0]), .in_pos(s_tdata[9:2]), .in_value(s_tdata[41:10]),
    .r_status(r_status), .r_item(r_item), .r_slot(r_slot), .r_count(r_count));

  assign m_tdata = {5'd0, r_count, r_slot, r_item, r_status};

`include "array_linked_list_manager_assert.svh"
  `ALM_ASSERT_IMP(a_excl, clk, rst, 1'b1, !(s_tready && m_tvalid))
  `ALM_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ALM_ASSERT_IMP(a_cnt, clk, rst, m_tvalid, r_count != 9'd0)
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the array linked list manager. A behavioural copy
// of the list table predicts every result. Commands run through directed
// corner cases, a fill to full, and random list traffic, with
// random idling on both stream sides and forced back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alm_pkg::*;

  localparam int SLOTS = 256;

  // packed from the highest field down, matching m_tdata[50:0]
  typedef struct packed {
    logic [8:0]  count;
    logic [7:0]  slot;
    logic [31:0] item_value;
    logic [1:0]  status;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  // shadow copy of the list table
  logic [31:0] sh_item [SLOTS];
  logic [7:0]  sh_next [SLOTS];
  logic [7:0]  sh_prev [SLOTS];
  logic        sh_used [SLOTS];
  logic [7:0]  sh_free_head;
  logic        sh_free_empty;
  logic [8:0]  sh_count;

  list_result_t result_q[$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;

  array_linked_list_manager u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // rebuild free chain from the used count upwards
  task automatic shadow_rebuild_free();
    for (int i = 0; i < SLOTS; i++) begin
      if (i >= sh_count) begin
        sh_item[i] = '0;
        sh_next[i] = (i + 1 < SLOTS) ? 8'(i + 1) : 8'd0;
        sh_prev[i] = '0;
        sh_used[i] = 1'b0;
      end
    end
    if (sh_count < SLOTS) begin
      sh_free_head  = 8'(sh_count);
      sh_free_empty = 1'b0;
    end else begin
      sh_free_head  = '0;
      sh_free_empty = 1'b1;
    end
  endtask

  task automatic shadow_reset();
    for (int i = 0; i < SLOTS; i++) begin
      sh_item[i] = '0;
      sh_prev[i] = '0;
      sh_used[i] = 1'b0;
    end
    sh_count   = 9'd1;
    sh_used[0] = 1'b1;
    sh_next[0] = '0;
    shadow_rebuild_free();
  endtask

  task automatic shadow_linearize();
    logic [31:0] order [SLOTS];
    logic [7:0]  cur;
    cur = sh_next[0];
    order[0] = sh_item[0];
    for (int i = 1; i < sh_count; i++) begin
      order[i] = sh_item[cur];
      cur = sh_next[cur];
    end
    for (int i = 0; i < sh_count; i++) begin
      sh_item[i] = order[i];
      sh_next[i] = (i + 1 < sh_count) ? 8'(i + 1) : 8'd0;
      sh_prev[i] = (i == 0) ? 8'(sh_count - 1) : 8'(i - 1);
      sh_used[i] = 1'b1;
    end
    shadow_rebuild_free();
  endtask

  // apply one command to the shadow table and return the expected result
  task automatic list_apply(input logic [1:0] cmd, input logic [7:0] pos,
                            input logic [31:0] val, output list_result_t res);
    logic [7:0] f, n, nf, p, cur;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        if (!sh_used[pos]) begin
          res.status = ST_BAD;
        end else if (sh_free_empty) begin
          res.status = ST_FULL;
        end else begin
          f  = sh_free_head;
          n  = sh_next[pos];
          nf = sh_next[f];
          sh_prev[n]   = f;
          sh_item[f]   = val;
          sh_next[f]   = n;
          sh_next[pos] = f;
          sh_prev[f]   = pos;
          sh_used[f]   = 1'b1;
          sh_count     = sh_count + 9'd1;
          if (sh_count >= SLOTS) begin
            sh_free_empty = 1'b1;
            sh_free_head  = '0;
          end else begin
            sh_free_head = nf;
          end
          res.slot = f;
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || !sh_used[pos]) begin
          res.status = ST_BAD;
        end else begin
          p = sh_prev[pos];
          n = sh_next[pos];
          res.item_value = sh_item[pos];
          sh_next[p]    = n;
          sh_prev[n]    = p;
          sh_item[pos]  = '0;
          sh_next[pos]  = sh_free_empty ? 8'd0 : sh_free_head;
          sh_prev[pos]  = '0;
          sh_used[pos]  = 1'b0;
          sh_free_head  = pos;
          sh_free_empty = 1'b0;
          sh_count      = sh_count - 9'd1;
        end
      end
      CMD_FIND: begin
        if (pos > sh_count) begin
          res.status = ST_BAD;
        end else begin
          cur = '0;
          for (int i = 0; i < pos; i++) cur = sh_next[cur];
          res.slot = cur;
        end
      end
      default: shadow_linearize();
    endcase
    res.count = sh_count;
  endtask

  // one command transaction; inputs change on the falling edge
  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] pos,
                          input logic [31:0] val);
    list_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, pos, cmd};
    do @(posedge clk); while (!s_tready);
    list_apply(cmd, pos, val, res);
    result_q.push_back(res);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // random slot in use; skips the sentinel if asked
  function automatic logic [7:0] pick_used(input bit skip_head);
    int start;
    start = $urandom_range(SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (sh_used[(start + k) % SLOTS] && !(skip_head && (start + k) % SLOTS == 0))
        return 8'((start + k) % SLOTS);
    end
    return 8'd0;
  endfunction

  // receiver: random ready, or a counted hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    list_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[50:0];
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d value %h/%h slot %0d/%0d count %0d/%0d",
                     want.status, got.status, want.item_value, got.item_value,
                     want.slot, got.slot, want.count, got.count);
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_FIND, 8'd0, 32'h0);
    send_cmd(CMD_FIND, 8'd1, 32'h0);        // index equal to count wraps
    send_cmd(CMD_FIND, 8'd255, 32'hFFFFFFFF); // beyond count
    send_cmd(CMD_DELETE, 8'd0, 32'h0);      // sentinel
    send_cmd(CMD_DELETE, 8'd7, 32'h0);      // unused slot
    send_cmd(CMD_INSERT, 8'd9, 32'h1234);   // after unused slot
    send_cmd(CMD_INSERT, 8'd0, 32'hFFFFFFFF);
    send_cmd(CMD_INSERT, 8'd0, 32'h0);
    send_cmd(CMD_INSERT, 8'd1, 32'hA5A5A5A5);
    send_cmd(CMD_INSERT, 8'd3, 32'h5A5A5A5A);
    send_cmd(CMD_FIND, 8'd3, 32'h0);
    send_cmd(CMD_FIND, 8'd5, 32'h0);
    send_cmd(CMD_FIND, 8'd6, 32'h0);
    send_cmd(CMD_DELETE, 8'd2, 32'h0);
    send_cmd(CMD_DELETE, 8'd2, 32'h0);      // already freed
    send_cmd(CMD_INSERT, 8'd4, 32'h80000001); // reuses freed slot
    send_cmd(CMD_LINEAR, 8'd0, 32'h0);
    send_cmd(CMD_FIND, 8'd4, 32'h0);
    send_cmd(CMD_DELETE, 8'd4, 32'h0);
    send_cmd(CMD_LINEAR, 8'hFF, 32'hFFFFFFFF);
    wait_drained();
  endtask

  // fill the table, hit the full case, then empty most of it
  task automatic test_fill();
    while (sh_count < SLOTS) send_cmd(CMD_INSERT, pick_used(0), $urandom());
    send_cmd(CMD_INSERT, 8'd255, $urandom());
    send_cmd(CMD_INSERT, 8'd0, $urandom());
    send_cmd(CMD_FIND, 8'd255, 32'h0);
    send_cmd(CMD_DELETE, 8'd255, 32'h0);
    send_cmd(CMD_INSERT, 8'd128, $urandom());
    send_cmd(CMD_LINEAR, 8'd0, 32'h0);
    while (sh_count > 8) send_cmd(CMD_DELETE, pick_used(1), 32'h0);
    wait_drained();
  endtask

  task automatic test_random(input int n, input int tx_pct, input int rx_pct);
    int r;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (sh_count < 6 && r >= 40 && r < 70) r = 0;
      if (sh_count > 200 && r < 40) r = 40;
      if (r < 40)
        send_cmd(CMD_INSERT, pick_used(0), $urandom());
      else if (r < 70)
        send_cmd(CMD_DELETE, pick_used(1), 32'h0);
      else if (r < 88)
        send_cmd(CMD_FIND, 8'($urandom_range(sh_count + 2 > 255 ? 255 : sh_count + 2)),
                 32'h0);
      else if (r < 91)
        send_cmd(CMD_LINEAR, 8'($urandom()), $urandom());
      else
        send_cmd(2'($urandom()), 8'($urandom()), $urandom());
    end
    wait_drained();
  endtask

  // long receiver stall while commands keep coming
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk);
    rx_hold = 400;
    for (int k = 0; k < 6; k++) send_cmd(CMD_INSERT, pick_used(0), $urandom());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    shadow_reset();
    test_directed();
    test_fill();
    test_random(205, 29, 62);
    test_backpressure();
    test_random(205, 62, 29);
    test_random(205, 0, 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/alm_pkg.sv
rtl/alm_ram.sv
rtl/alm_datapath.sv
rtl/alm_ctrl.sv
rtl/array_linked_list_manager.sv
test/tb_top.sv
